// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types and constants for the ring-buffer deque and its testbench.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default configuration.
  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths of the stream interface.
  localparam int KIND_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 4;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_REAR  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_REAR   = 3'd3,
    K_PEEK_FRONT = 3'd4,
    K_PEEK_REAR  = 3'd5,
    K_SEARCH     = 3'd6,
    K_COUNT      = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_HOLD
  } state_t;

  // One result item.
  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  value;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
  } result_t;

endpackage

// ----- design/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Deque ring storage
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of words with push, pop, peek, search and count requests.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH words of WORD_BITS bits in one synchronous RAM
// used as a ring, with a front pointer and an entry count in flip-flops. Each
// request transfer on the slave side names an operation in tuser and carries a
// word in tdata; exactly one result transfer follows on the master side, in
// request order. Pushes, count requests and every refused request (push into a
// full queue, pop, peek or search on an empty one) finish in the cycle they
// are accepted, and a new request can be taken every cycle while their results
// can leave. Pops and peeks wait for the registered RAM read, so no new request
// is taken until the read data has returned. A search reads the ring one entry
// per cycle from the front, pipelined against the compare, and takes no new
// request until a match or the last held entry ends it. Results go through an
// output register, so a new request is accepted while a finished result still
// waits for the master side; only when a second result is ready before the
// first has left does the block hold it and pause intake. Only entries that a
// push has written are ever used, so the RAM needs no clearing after reset.
// Words pushed are the low WORD_BITS bits of the request word; popped and
// peeked words are returned sign-extended from WORD_BITS to 32 bits. Position
// and occupancy are reported in their low bits only.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value_in
  input  logic [deq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [2:0] kind
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] value_out,
                                                         // [35:32] position,
                                                         // [40:36] occupancy,
                                                         // [47:41] zero
  output logic [deq_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // [1:0] status, [2] found
);

  import deq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Ring index of the entry at a given offset from a base pointer. The sum
  // stays below twice the depth, so one compare and subtract wraps it.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Control state.
  state_t           state;
  state_t           state_next;
  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Search scan: read issue index, and the index whose data returns now.
  logic [CNT_W-1:0] scan_rd;
  logic [CNT_W-1:0] scan_rd_next;
  logic             cmp_pend;
  logic             cmp_pend_next;
  logic [CNT_W-1:0] cmp_idx;
  logic [CNT_W-1:0] cmp_idx_next;
  logic [WORD_BITS-1:0] key;

  // RAM port.
  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Result path.
  logic    fin_valid;
  result_t fin;
  result_t held;
  result_t out_res;
  logic    out_free;
  logic    load_fin;
  logic    load_held;

  logic                 s_fire;
  kind_t                req_kind;
  logic [WORD_BITS-1:0] req_word;
  logic                 empty;
  logic                 full;
  logic                 scan_hit;
  logic                 scan_end;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign req_kind      = kind_t'(s_axis_tuser);
  assign req_word      = WORD_BITS'(s_axis_tdata);
  assign empty         = (count == '0);
  assign full          = (count == CNT_W'(DEPTH));
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign scan_hit      = cmp_pend && (ram_rdata == key);
  assign scan_end      = cmp_pend && (scan_rd == count);

  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (!empty && (req_kind == K_POP_FRONT || req_kind == K_POP_REAR ||
                         req_kind == K_PEEK_FRONT || req_kind == K_PEEK_REAR)) begin
            state_next = S_RDWAIT;
          end else if (!empty && req_kind == K_SEARCH) begin
            state_next = S_SCAN;
          end else if (!out_free) begin
            state_next = S_HOLD;
          end
        end
      end
      S_RDWAIT: begin
        state_next = out_free ? S_IDLE : S_HOLD;
      end
      S_SCAN: begin
        if (fin_valid) begin
          state_next = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control, RAM accesses and the finished result.
  always_comb begin
    front_next    = front;
    count_next    = count;
    scan_rd_next  = scan_rd;
    cmp_pend_next = 1'b0;
    cmp_idx_next  = scan_rd;
    ram_we        = 1'b0;
    ram_waddr     = front;
    ram_wdata     = req_word;
    ram_raddr     = front;
    fin_valid     = 1'b0;
    fin           = '0;
    fin.status    = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          unique case (req_kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
              fin_valid = 1'b1;
              if (full) begin
                fin.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + 1'b1;
                if (req_kind == K_PUSH_FRONT) begin
                  front_next = (front == '0) ? PTR_W'(DEPTH - 1) : front - 1'b1;
                  ram_waddr  = front_next;
                end else begin
                  ram_waddr = ring_add(front, count);
                end
              end
            end
            K_POP_FRONT, K_POP_REAR, K_PEEK_FRONT, K_PEEK_REAR: begin
              if (empty) begin
                fin_valid  = 1'b1;
                fin.status = ST_EMPTY;
              end else begin
                if (req_kind == K_POP_FRONT || req_kind == K_PEEK_FRONT) begin
                  ram_raddr = front;
                end else begin
                  ram_raddr = ring_add(front, count - 1'b1);
                end
                if (req_kind == K_POP_FRONT) begin
                  front_next = ring_add(front, CNT_W'(1));
                  count_next = count - 1'b1;
                end else if (req_kind == K_POP_REAR) begin
                  count_next = count - 1'b1;
                end
              end
            end
            K_SEARCH: begin
              scan_rd_next = '0;
              if (empty) begin
                fin_valid  = 1'b1;
                fin.status = ST_EMPTY;
              end
            end
            K_COUNT: begin
              fin_valid = 1'b1;
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        fin_valid = 1'b1;
        fin.value = VALUE_W'(signed'(ram_rdata));
      end
      S_SCAN: begin
        // Issue one read per cycle while entries remain; the compare of the
        // entry read in the previous cycle runs alongside.
        ram_raddr = ring_add(front, scan_rd);
        if (scan_rd != count) begin
          scan_rd_next  = scan_rd + 1'b1;
          cmp_pend_next = 1'b1;
        end
        if (scan_hit) begin
          fin_valid    = 1'b1;
          fin.found    = 1'b1;
          fin.position = POS_W'(cmp_idx);
        end else if (scan_end) begin
          fin_valid  = 1'b1;
          fin.status = ST_MISS;
        end
      end
      S_HOLD: begin
        fin_valid = 1'b0;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase

    fin.occupancy = OCC_W'(count_next);
  end

  assign load_fin  = fin_valid && out_free;
  assign load_held = (state == S_HOLD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      front         <= '0;
      count         <= '0;
      scan_rd       <= '0;
      cmp_pend      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      count    <= count_next;
      scan_rd  <= scan_rd_next;
      cmp_pend <= cmp_pend_next;
      if (load_fin || load_held) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    if (s_fire) begin
      key <= req_word;
    end
    if (fin_valid && !out_free) begin
      held <= fin;
    end
    if (load_fin) begin
      out_res <= fin;
    end else if (load_held) begin
      out_res <= held;
    end
  end

  assign m_axis_tdata = {7'd0, out_res.occupancy, out_res.position, out_res.value};
  assign m_axis_tuser = {out_res.found, out_res.status};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Streams push, pop, peek, search and count requests into the ring-buffer
// deque under random flow control. A shadow deque in the bench predicts every
// result, and each result transfer is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int RING_DEPTH     = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1080;
  // Requests this close to the end run with both sides streaming freely.
  localparam int QUIET_TAIL     = 150;
  // The sender waits for an empty result backlog before this request.
  localparam int PAUSE_AT       = 560;
  // The receiver starts its long hold-off after this many results.
  localparam int HOLD_AFTER     = 200;
  localparam int HOLD_CYCLES    = 400;
  // The tail wait is long enough for the longest search to finish.
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  // One request as the sender queues it. A set drain_first makes the sender
  // hold it back until every earlier result has been received.
  typedef struct {
    kind_t       kind;
    logic [31:0] word;
    bit          drain_first;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  always #5 clk = ~clk;

  double_ended_queue dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value_in
    .s_axis_tuser  (s_axis_tuser),   // [2:0] kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] value_out, [35:32] position,
                                     // [40:36] occupancy, [47:41] zero
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status, [2] found
  );

  // Requests not yet offered, and results the block still owes, oldest first.
  request_t request_backlog[$];
  result_t  owed_results[$];

  int requests_sent = 0;
  int results_seen  = 0;
  int total_items   = 0;
  int errors        = 0;

  // Shadow copy of the deque contents, updated as each request is accepted.
  logic [31:0] shadow_ring[RING_DEPTH];
  int          shadow_front = 0;
  int          shadow_count = 0;

  // Words pushed recently, reused as search keys so that searches hit often.
  logic [31:0] recent_words[$];

  // Works out the result of one request and updates the shadow deque the way
  // the block updates its ring. The word width equals the output width, so
  // popped and peeked words come back unchanged.
  function automatic result_t deque_apply(request_t rq);
    result_t res;
    int      slot;
    bit      hit;
    res        = '0;
    res.status = ST_OK;
    hit        = 1'b0;
    case (rq.kind)
      K_PUSH_FRONT, K_PUSH_REAR: begin
        if (shadow_count >= RING_DEPTH) begin
          res.status = ST_FULL;
        end else if (rq.kind == K_PUSH_FRONT) begin
          shadow_front = (shadow_front + RING_DEPTH - 1) % RING_DEPTH;
          shadow_ring[shadow_front] = rq.word;
          shadow_count++;
        end else begin
          shadow_ring[(shadow_front + shadow_count) % RING_DEPTH] = rq.word;
          shadow_count++;
        end
      end
      K_POP_FRONT, K_POP_REAR, K_PEEK_FRONT, K_PEEK_REAR: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (rq.kind == K_POP_FRONT || rq.kind == K_PEEK_FRONT) begin
            slot = shadow_front;
          end else begin
            slot = (shadow_front + shadow_count - 1) % RING_DEPTH;
          end
          res.value = shadow_ring[slot];
          if (rq.kind == K_POP_FRONT) begin
            shadow_front = (shadow_front + 1) % RING_DEPTH;
            shadow_count--;
          end else if (rq.kind == K_POP_REAR) begin
            shadow_count--;
          end
        end
      end
      K_SEARCH: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_MISS;
          // The first match counted from the front wins.
          for (int i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_ring[(shadow_front + i) % RING_DEPTH] == rq.word) begin
              hit          = 1'b1;
              res.status   = ST_OK;
              res.found    = 1'b1;
              res.position = i[POS_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  // Both sides idle at random except in one calm window and in the tail.
  function automatic bit idling_allowed();
    return (requests_sent < total_items - QUIET_TAIL) &&
           !(requests_sent >= 300 && requests_sent < 420);
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Mostly random words, with a bias toward the extremes and toward a few
  // small values so that the ring holds duplicates for the search.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1:       return ($urandom_range(0, 1) != 0) ? 32'h0000_0000 : 32'hffff_ffff;
      2, 3, 4: return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_request(kind_t kind, logic [31:0] word, bit drain_first);
    request_t rq;
    rq.kind        = kind;
    rq.word        = word;
    rq.drain_first = drain_first;
    request_backlog.push_back(rq);
    if (kind == K_PUSH_FRONT || kind == K_PUSH_REAR) begin
      recent_words.push_back(word);
      if (recent_words.size() > 24) begin
        void'(recent_words.pop_front());
      end
    end
  endfunction

  // Sender. A request stays on the bus until its transfer; after a transfer
  // the sender may go quiet for a random burst of cycles.
  request_t on_bus;
  int       send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(deque_apply(on_bus));
        requests_sent++;
        if (idling_allowed() && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(1, 16);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain_first && owed_results.size() != 0)) begin
          on_bus = request_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.word;
          s_axis_tuser  <= on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. It checks each result transfer against the oldest owed result
  // and stalls in random bursts. Once, it holds off long enough for the
  // block to fill its output stage and stop taking requests.
  result_t want;
  int      stall_left     = 0;
  bit      long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: tdata 0x%0h, tuser 0x%0h", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("status",    want.status,    m_axis_tuser[1:0]);
          check_field("found",     want.found,     m_axis_tuser[2]);
          check_field("value_out", want.value,     m_axis_tdata[31:0]);
          check_field("position",  want.position,  m_axis_tdata[35:32]);
          check_field("occupancy", want.occupancy, m_axis_tdata[40:36]);
          check_field("tdata pad", 0,              m_axis_tdata[47:41]);
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int       push_pct;
    int       run_len;
    int       pick;
    kind_t    kind;
    logic [31:0] word;

    // Directed opening: every non-push request on an empty deque (count still
    // succeeds, the rest underflow), pushes of the extreme words at both
    // ends, peeks, searches that hit, one that misses, and a full drain.
    add_request(K_COUNT,      32'h0, 1'b0);
    add_request(K_POP_FRONT,  32'h0, 1'b0);
    add_request(K_POP_REAR,   32'h0, 1'b0);
    add_request(K_PEEK_FRONT, 32'h0, 1'b0);
    add_request(K_PEEK_REAR,  32'h0, 1'b0);
    add_request(K_SEARCH,     32'h0, 1'b0);
    add_request(K_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    add_request(K_PUSH_REAR,  32'h8000_0000, 1'b0);
    add_request(K_PUSH_FRONT, 32'h0000_0000, 1'b0);
    add_request(K_PUSH_REAR,  32'hffff_ffff, 1'b0);
    add_request(K_PEEK_FRONT, 32'h0, 1'b0);
    add_request(K_PEEK_REAR,  32'h0, 1'b0);
    add_request(K_SEARCH,     32'h8000_0000, 1'b0);
    add_request(K_SEARCH,     32'hffff_ffff, 1'b0);
    add_request(K_SEARCH,     32'h0000_0005, 1'b0);
    add_request(K_COUNT,      32'h0, 1'b0);
    add_request(K_POP_FRONT,  32'h0, 1'b0);
    add_request(K_POP_REAR,   32'h0, 1'b0);
    add_request(K_POP_FRONT,  32'h0, 1'b0);
    add_request(K_POP_REAR,   32'h0, 1'b0);
    add_request(K_COUNT,      32'h0, 1'b0);

    // Fill past capacity so that the last pushes are refused as overflow.
    repeat (RING_DEPTH + 4) begin
      add_request(($urandom_range(0, 1) != 0) ? K_PUSH_REAR : K_PUSH_FRONT,
                  pick_word(), 1'b0);
    end

    // Random runs that lean toward filling or toward draining, so that the
    // deque keeps crossing between empty and full and the ring wraps often.
    while (request_backlog.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        word = pick_word();
        if (pick < push_pct) begin
          kind = ($urandom_range(0, 1) != 0) ? K_PUSH_REAR : K_PUSH_FRONT;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            kind = ($urandom_range(0, 1) != 0) ? K_POP_REAR : K_POP_FRONT;
          end else if (pick < 65) begin
            kind = ($urandom_range(0, 1) != 0) ? K_PEEK_REAR : K_PEEK_FRONT;
          end else if (pick < 90) begin
            kind = K_SEARCH;
            if (recent_words.size() != 0 && $urandom_range(0, 9) < 7) begin
              word = recent_words[$urandom_range(0, recent_words.size() - 1)];
            end
          end else begin
            kind = K_COUNT;
          end
        end
        add_request(kind, word, request_backlog.size() == PAUSE_AT);
      end
    end
    total_items = request_backlog.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent < total_items || owed_results.size() != 0) begin
      @(posedge clk);
    end
    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
dv/tb_top.sv
